// File: hw/rtl/izh_pkg.sv
// Shared types, constants and helpers for the Izhikevich neuron step block.
package izh_pkg;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [47:0] wide_t;
	typedef logic [24:0] energy_t;
	typedef logic [20:0] tstep_t;

	// Request to the shared multiplier
	typedef struct packed {
		logic start;
		logic shift32;
	} mul_req_t;

	localparam q16_t K_SQUARE = 32'sd171798692;
	localparam q16_t K_BIAS = 32'sd9175040;
	localparam q16_t K_THRESH = 32'sd1966080;
	localparam energy_t E_ONE = 25'd16777216;
	localparam energy_t E_COST = 25'd83886;
	// Recharge is floor(dt * 8 / 3125): estimate with floor(2^35 / 3125), then correct
	localparam q16_t RECHARGE_MUL = 32'sd10995116;
	localparam int RECHARGE_DIV = 3125;
	localparam int INC_W = 13;

	// Clamp a sum to the signed 32-bit range
	function automatic q16_t sat32(input logic signed [48:0] x);
		q16_t r;
		if (x > 49'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -49'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = q16_t'(x[31:0]);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/izhikevich_neuron_step.sv
// Top level of the Izhikevich neuron step: configuration, state, sequencer and output register.
//
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------------
// input    | in_valid / in_stall   | command, stimulus_current
// output   | out_valid / out_stall | spiked, potential_out, recovery_out, energy_out
// config   | cfg_write             | cfg_index, cfg_data
//
// An advance beat runs seven multiplications through the one shared 32x32 multiplier,
// then the correction, update and output steps. A reinitialize beat runs one multiplication
// only with automatic recovery, and none without it.
// Reset loads the default configuration and the resting state; no clearing pass.
// The input is stalled while a beat is in work; a finished result waits in the output register
// and the next beat may be accepted meanwhile.
module izhikevich_neuron_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  izh_pkg::q16_t        stimulus_current,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 spiked,
	output izh_pkg::q16_t        potential_out,
	output izh_pkg::q16_t        recovery_out,
	output izh_pkg::energy_t     energy_out,
	input  logic                 cfg_write,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import izh_pkg::*;

	typedef enum logic [2:0] {
		CFG_A, CFG_B, CFG_C, CFG_D, CFG_DT, CFG_INIT_V, CFG_INIT_U, CFG_AUTO
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_KS, S_DV, S_BV, S_AD, S_DU, S_INC, S_FIX, S_UPD, S_RB, S_EMIT
	} state_t;

	typedef logic signed [36:0] lin_t;

	state_t state_q;
	state_t mul_next;

	// Configuration
	q16_t a_q, b_q, c_q, d_q, init_v_q, init_u_q;
	tstep_t dt_q;
	logic auto_q;

	// Neuron state
	q16_t v_q, u_q;
	energy_t e_q;
	logic spk_q;

	// Working registers
	lin_t lin_q;
	wide_t w_q;
	q16_t vn_q, un_q;
	logic [INC_W-1:0] inc_q;

	// Output register
	logic out_valid_q;
	logic spiked_q;
	q16_t pot_q, rec_q;
	energy_t en_q;

	logic busy_q;
	logic is_mul;
	logic in_accept;
	mul_req_t mul_req;
	wide_t mul_x;
	q16_t mul_y;
	logic mul_done;
	wide_t mul_res;

	lin_t lin;
	logic spk;
	q16_t v_next, u_next;
	energy_t e_cost, e_next;
	logic [24:0] rem;

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign spiked = spiked_q;
	assign potential_out = pot_q;
	assign recovery_out = rec_q;
	assign energy_out = en_q;

	// Select multiplier operands for each step
	always_comb begin
		is_mul = 1'b1;
		mul_next = S_IDLE;
		mul_x = w_q;
		mul_y = '0;
		mul_req.shift32 = 1'b0;
		unique case (state_q) inside
			S_SQ: begin
				mul_x = 48'(v_q);
				mul_y = v_q;
				mul_next = S_KS;
			end
			S_KS: begin
				mul_y = K_SQUARE;
				mul_req.shift32 = 1'b1;
				mul_next = S_DV;
			end
			S_DV: begin
				mul_y = {11'b0, dt_q};
				mul_next = S_BV;
			end
			S_BV: begin
				mul_x = 48'(b_q);
				mul_y = v_q;
				mul_next = S_AD;
			end
			S_AD: begin
				mul_y = a_q;
				mul_next = S_DU;
			end
			S_DU: begin
				mul_y = {11'b0, dt_q};
				mul_next = S_INC;
			end
			S_INC: begin
				mul_x = {27'b0, dt_q};
				mul_y = RECHARGE_MUL;
				mul_req.shift32 = 1'b1;
				mul_next = S_FIX;
			end
			S_RB: begin
				mul_x = 48'(b_q);
				mul_y = v_q;
				mul_next = S_EMIT;
			end
			S_IDLE, S_FIX, S_UPD, S_EMIT: is_mul = 1'b0;
		endcase
		mul_req.start = is_mul && !busy_q;
	end

	izh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.res    (mul_res)
	);

	// Linear part of the potential derivative, taken at acceptance
	always_comb begin
		lin = (37'(v_q) <<< 2) + 37'(v_q) + 37'(K_BIAS) - 37'(u_q) + 37'(stimulus_current);
	end

	// Spike handling and energy bookkeeping
	always_comb begin
		spk = (vn_q >= K_THRESH);
		v_next = spk ? c_q : vn_q;
		u_next = spk ? sat32(49'(un_q) + 49'(d_q)) : un_q;
		if (spk) begin
			e_cost = (e_q > E_COST) ? (e_q - E_COST) : '0;
		end else begin
			e_cost = e_q;
		end
		e_next = ((E_ONE - e_cost) <= 25'(inc_q)) ? E_ONE : (e_cost + 25'(inc_q));
		rem = 25'({dt_q, 3'b000}) - 25'(inc_q) * 25'(RECHARGE_DIV);
	end

	// Sequencer, configuration, neuron state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			a_q <= 32'sd1311;
			b_q <= 32'sd13107;
			c_q <= -32'sd4259840;
			d_q <= 32'sd524288;
			dt_q <= 21'd65536;
			init_v_q <= -32'sd4259840;
			init_u_q <= -32'sd851968;
			auto_q <= 1'b1;
			v_q <= -32'sd4259840;
			u_q <= -32'sd851968;
			e_q <= E_ONE;
			spk_q <= 1'b0;
			out_valid_q <= 1'b0;
			spiked_q <= 1'b0;
			pot_q <= '0;
			rec_q <= '0;
			en_q <= '0;
		end else begin
			// Register writes
			if (cfg_write) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_A:      a_q <= cfg_data;
					CFG_B:      b_q <= cfg_data;
					CFG_C:      c_q <= cfg_data;
					CFG_D:      d_q <= cfg_data;
					CFG_DT:     dt_q <= cfg_data[20:0];
					CFG_INIT_V: init_v_q <= cfg_data;
					CFG_INIT_U: init_u_q <= cfg_data;
					CFG_AUTO:   auto_q <= cfg_data[0];
				endcase
			end

			// Drop the output beat once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end

			// Hold the multiplier busy flag
			if (mul_req.start) begin
				busy_q <= 1'b1;
			end
			if (mul_done) begin
				busy_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (command) begin
							v_q <= init_v_q;
							e_q <= E_ONE;
							spk_q <= 1'b0;
							if (auto_q) begin
								state_q <= S_RB;
							end else begin
								u_q <= init_u_q;
								state_q <= S_EMIT;
							end
						end else begin
							state_q <= S_SQ;
						end
					end
				end
				S_SQ, S_KS, S_DV, S_BV, S_AD, S_DU, S_INC: begin
					if (mul_done) state_q <= mul_next;
				end
				S_RB: begin
					if (mul_done) begin
						u_q <= sat32(49'(mul_res));
						state_q <= mul_next;
					end
				end
				S_FIX: state_q <= S_UPD;
				S_UPD: begin
					v_q <= v_next;
					u_q <= u_next;
					e_q <= e_next;
					spk_q <= spk;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						spiked_q <= spk_q;
						pot_q <= v_q;
						rec_q <= u_q;
						en_q <= e_q;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Working registers of the Euler step
	always_ff @(posedge clk) begin
		if (in_accept) begin
			lin_q <= lin;
		end
		case (state_q)
			S_SQ: if (mul_done) w_q <= mul_res;
			S_KS: if (mul_done) w_q <= mul_res + 48'(lin_q);
			S_DV: if (mul_done) vn_q <= sat32(49'(v_q) + 49'(mul_res));
			S_BV: if (mul_done) w_q <= mul_res - 48'(u_q);
			S_AD: if (mul_done) w_q <= mul_res;
			S_DU: if (mul_done) un_q <= sat32(49'(u_q) + 49'(mul_res));
			S_INC: if (mul_done) inc_q <= mul_res[INC_W-1:0];
			// Correct the reciprocal estimate by one where the remainder is too large
			S_FIX: inc_q <= inc_q + INC_W'(rem >= 25'(RECHARGE_DIV));
			default: ;
		endcase
	end

	// Energy never exceeds one
	a_energy_cap: assert property (@(posedge clk) disable iff (!arst_n)
		e_q <= E_ONE) else $error("energy above one");
	// A multiplier result arrives only for a request in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> busy_q && is_mul) else $error("unexpected multiplier result");
	// An accepted beat always starts work
	a_accept_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q != S_IDLE) else $error("accepted beat dropped");

endmodule

// File: hw/rtl/izh_mul.sv
// Shared sign-magnitude fixed-point multiplier: two 32x32 partial products, shift, saturate.
module izh_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  izh_pkg::mul_req_t req,
	input  izh_pkg::wide_t    x,
	input  izh_pkg::q16_t     y,
	output logic              done,
	output izh_pkg::wide_t    res
);
	import izh_pkg::*;

	typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_ADD, M_FIN} mstate_t;

	mstate_t state_q;
	logic [47:0] mx_q;
	logic [31:0] my_q;
	logic neg_q;
	logic s32_q;
	logic [63:0] prod_q;
	logic [79:0] acc_q;

	logic [47:0] mag_x;
	logic [31:0] mag_y;
	logic [31:0] mop;
	logic [63:0] prod;
	logic [63:0] sh;
	logic sat;
	logic [46:0] mag_r;

	// Magnitudes of the operands
	always_comb begin
		mag_x = x[47] ? 48'(-x) : 48'(x);
		mag_y = y[31] ? 32'(-y) : 32'(y);
	end

	// Single 32x32 multiplier: low half of x first, then high half
	always_comb begin
		mop = (state_q == M_LO) ? mx_q[31:0] : {16'b0, mx_q[47:32]};
		prod = 64'(mop) * 64'(my_q);
	end

	// Shift, saturate and restore the sign
	always_comb begin
		sh = s32_q ? {16'b0, acc_q[79:32]} : acc_q[79:16];
		sat = |sh[63:47];
		mag_r = sat ? {47{1'b1}} : sh[46:0];
		res = neg_q ? -wide_t'({1'b0, mag_r}) : wide_t'({1'b0, mag_r});
		done = (state_q == M_FIN);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			unique case (state_q)
				M_IDLE: if (req.start) state_q <= M_LO;
				M_LO:   state_q <= M_HI;
				M_HI:   state_q <= M_ADD;
				M_ADD:  state_q <= M_FIN;
				M_FIN:  state_q <= M_IDLE;
			endcase
		end
	end

	// Operand and accumulator registers
	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (req.start) begin
					mx_q <= mag_x;
					my_q <= mag_y;
					neg_q <= x[47] ^ y[31];
					s32_q <= req.shift32;
				end
			end
			M_LO: prod_q <= prod;
			M_HI: begin
				prod_q <= prod;
				acc_q <= {16'b0, prod_q};
			end
			M_ADD: acc_q <= acc_q + {prod_q[47:0], 32'b0};
			default: ;
		endcase
	end

	// Start only when free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == M_IDLE) else $error("multiplier started while busy");
	// Fixed latency from start to result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> ##4 done) else $error("multiplier result late");
	// Result magnitude never exceeds the 47-bit limit
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res != 48'sh8000_0000_0000) else $error("multiplier result out of range");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the Izhikevich neuron step block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {
		CMD_ADVANCE = 1'b0,
		CMD_REINIT  = 1'b1
	} neuron_cmd_e;

	typedef enum logic [2:0] {
		REG_RATE        = 3'd0,
		REG_SENSITIVITY = 3'd1,
		REG_RESET_POT   = 3'd2,
		REG_JUMP        = 3'd3,
		REG_TIME_STEP   = 3'd4,
		REG_INIT_POT    = 3'd5,
		REG_INIT_REC    = 3'd6,
		REG_AUTO_REC    = 3'd7
	} reg_index_e;

	typedef logic [31:0] reg_set_t [8];

	typedef struct {
		bit     spk;
		longint pot;
		longint rec;
		longint en;
	} tick_out_t;

	localparam longint WIDE_LIM    = 64'sd140737488355327;
	localparam longint SQUARE_COEF = 64'sd171798692;
	localparam longint BIAS_140    = 64'sd9175040;
	localparam longint THRESH_30   = 64'sd1966080;
	localparam longint ENERGY_FULL = 64'sd16777216;
	localparam longint SPIKE_COST  = 64'sd83886;
	localparam int     QUIET_LIMIT = 4000;
	localparam int     LONG_HOLD   = 600;
	localparam int     TICK_CYCLES = 39;

	// Tracks the neuron state and holds the ticks whose results are still owed
	class neuron_tracker;
		longint rate, sens, reset_pot, jump, init_pot, init_rec, tstep;
		bit auto_rec;
		longint membrane, recov, energy;
		tick_out_t ticks_due[$];
		int errors;

		function new();
			rate = 1311;
			sens = 13107;
			reset_pot = -4259840;
			jump = 524288;
			tstep = 65536;
			init_pot = -4259840;
			init_rec = -851968;
			auto_rec = 1'b1;
			membrane = -4259840;
			recov = -851968;
			energy = ENERGY_FULL;
			errors = 0;
		endfunction

		// |x|*|y| >> s, saturated at the 48-bit limit, sign restored afterwards
		function longint scaled_product(longint x, longint y, int s);
			logic [127:0] mx, my, p;
			longint r;
			mx = (x < 0) ? 128'(-x) : 128'(x);
			my = (y < 0) ? 128'(-y) : 128'(y);
			p = (mx * my) >> s;
			if (p > 128'(WIDE_LIM)) begin
				p = 128'(WIDE_LIM);
			end
			r = longint'(p[63:0]);
			return ((x < 0) != (y < 0)) ? -r : r;
		endfunction

		function longint clamp32(longint x);
			if (x > 64'sd2147483647) begin
				return 64'sd2147483647;
			end
			if (x < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return x;
		endfunction

		function void set_reg(reg_index_e idx, logic [31:0] data);
			case (idx)
				REG_RATE:        rate = longint'($signed(data));
				REG_SENSITIVITY: sens = longint'($signed(data));
				REG_RESET_POT:   reset_pot = longint'($signed(data));
				REG_JUMP:        jump = longint'($signed(data));
				REG_TIME_STEP:   tstep = longint'(data[20:0]);
				REG_INIT_POT:    init_pot = longint'($signed(data));
				REG_INIT_REC:    init_rec = longint'($signed(data));
				REG_AUTO_REC:    auto_rec = data[0];
				default: ;
			endcase
		endfunction

		// Advance or reload the neuron for one accepted beat and queue the result
		function void note_beat(neuron_cmd_e cmd, izh_pkg::q16_t cur);
			longint v, u, sq, br, dv, diff, du, inc;
			bit fired;
			tick_out_t t;
			fired = 1'b0;
			if (cmd == CMD_REINIT) begin
				membrane = init_pot;
				recov = auto_rec ? clamp32(scaled_product(sens, init_pot, 16)) : init_rec;
				energy = ENERGY_FULL;
			end else begin
				v = membrane;
				u = recov;
				sq = scaled_product(v, v, 16);
				br = scaled_product(sq, SQUARE_COEF, 32) + 5 * v + BIAS_140 - u
					+ longint'(cur);
				dv = scaled_product(br, tstep, 16);
				diff = scaled_product(sens, v, 16) - u;
				du = scaled_product(scaled_product(rate, diff, 16), tstep, 16);
				v = clamp32(v + dv);
				u = clamp32(u + du);
				if (v >= THRESH_30) begin
					v = reset_pot;
					u = clamp32(u + jump);
					fired = 1'b1;
					energy = (energy > SPIKE_COST) ? energy - SPIKE_COST : 0;
				end
				inc = (tstep * 256) / 100000;
				energy = (ENERGY_FULL - energy <= inc) ? ENERGY_FULL : energy + inc;
				membrane = v;
				recov = u;
			end
			t.spk = fired;
			t.pot = membrane;
			t.rec = recov;
			t.en = energy;
			ticks_due.push_back(t);
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Compare one result beat with the oldest owed tick
		function void check_beat(logic spk, izh_pkg::q16_t pot, izh_pkg::q16_t rec,
				izh_pkg::energy_t en);
			tick_out_t t;
			if (ticks_due.size() == 0) begin
				$error("result beat with no tick outstanding");
				errors++;
				return;
			end
			t = ticks_due.pop_front();
			compare_field("spiked", t.spk, spk);
			compare_field("potential_out", t.pot, pot);
			compare_field("recovery_out", t.rec, rec);
			compare_field("energy_out", t.en, en);
		endfunction

		function int pending();
			return ticks_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	izh_pkg::q16_t stimulus_current = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic spiked;
	izh_pkg::q16_t potential_out;
	izh_pkg::q16_t recovery_out;
	izh_pkg::energy_t energy_out;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	neuron_tracker tracker = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	izhikevich_neuron_step i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.stimulus_current(stimulus_current),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.spiked(spiked),
		.potential_out(potential_out),
		.recovery_out(recovery_out),
		.energy_out(energy_out),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Check result beats, then pick the next stall: a long hold when asked, else random
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			tracker.check_beat(spiked, potential_out, recovery_out, energy_out);
		end
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// End the run when no beat moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one beat after an optional random gap and hold it until taken
	task automatic send_item(neuron_cmd_e cmd, izh_pkg::q16_t cur);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		stimulus_current <= cur;
		do @(posedge clk); while (in_stall);
		tracker.note_beat(cmd, cur);
	endtask

	task automatic write_reg(reg_index_e idx, logic [31:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		tracker.set_reg(idx, data);
	endtask

	// Mostly plausible, else near zero or full range; mostly large positive to drain
	function automatic izh_pkg::q16_t pick_current(bit drain);
		int r;
		r = $urandom_range(99);
		if (drain && r < 95) begin
			return izh_pkg::q16_t'($urandom_range(32'h7FFF_FFFF, 32'h1000_0000));
		end
		if (r < 55) begin
			return izh_pkg::q16_t'(int'($urandom_range(3276800)) - 655360);
		end
		if (r < 75) begin
			return izh_pkg::q16_t'(int'($urandom_range(131072)) - 65536);
		end
		return izh_pkg::q16_t'($urandom);
	endfunction

	function automatic reg_set_t random_regs();
		reg_set_t rs;
		foreach (rs[i]) begin
			rs[i] = $urandom;
		end
		return rs;
	endfunction

	// Load a full register set, then run random beats and drain all results
	task automatic run_phase(reg_set_t rs, int count, int idle, int stall, bit drain);
		neuron_cmd_e cmd;
		for (int i = 0; i < 8; i++) begin
			write_reg(reg_index_e'(i), rs[i]);
		end
		@(posedge clk);
		cfg_write <= 1'b0;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			cmd = (!drain && $urandom_range(99) < 8) ? CMD_REINIT : CMD_ADVANCE;
			send_item(cmd, pick_current(drain));
		end
		in_valid <= 1'b0;
		while (tracker.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		reg_set_t regular, fast, chatter, frozen, ext_hi, ext_lo, bursting;
		regular  = '{32'd1311, 32'd13107, 32'hFFBF_0000, 32'd524288, 32'd65536,
			32'hFFBF_0000, 32'hFFF3_0000, 32'd1};
		fast     = '{32'd6554, 32'd13107, 32'hFFBF_0000, 32'd131072, 32'd32768,
			32'hFFBA_0000, 32'hFFF3_0000, 32'd0};
		chatter  = '{32'd1311, 32'd13107, 32'hFFCE_0000, 32'd131072, 32'd65536,
			32'hFFBF_0000, 32'hFFF2_0000, 32'd1};
		frozen   = '{32'd1311, 32'd13107, 32'hFFBF_0000, 32'd524288, 32'd0,
			32'h0028_0000, 32'hFFF3_0000, 32'd1};
		ext_hi   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h001F_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0};
		ext_lo   = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1};
		bursting = '{32'd1311, 32'd13107, 32'hFFC9_0000, 32'd262144, 32'd1048576,
			32'hFFBF_0000, 32'hFFF3_0000, 32'd0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats on the reset configuration
		send_item(CMD_ADVANCE, 32'sd0);
		send_item(CMD_REINIT, 32'sh7FFF_FFFF);
		send_item(CMD_ADVANCE, 32'sd655360);
		send_item(CMD_ADVANCE, 32'sd655360);
		send_item(CMD_ADVANCE, 32'sh7FFF_FFFF);
		send_item(CMD_ADVANCE, 32'sh8000_0000);
		send_item(CMD_ADVANCE, 32'sh8000_0000);
		send_item(CMD_ADVANCE, -32'sd1);
		send_item(CMD_REINIT, 32'sh8000_0000);
		send_item(CMD_ADVANCE, 32'sh7FFF_FFFF);
		send_item(CMD_ADVANCE, 32'sh7FFF_FFFF);
		send_item(CMD_ADVANCE, 32'sd1);
		send_item(CMD_ADVANCE, 32'sh5555_5555);
		send_item(CMD_ADVANCE, 32'shAAAA_AAAA);
		for (int n = 0; n < 6; n++) begin
			send_item(CMD_ADVANCE, 32'sd655360);
		end
		in_valid <= 1'b0;
		while (tracker.pending() != 0) begin
			@(posedge clk);
		end

		// Fill the block with a long output hold while beats keep coming
		hold_req = 1'b1;
		run_phase(regular, 55, 0, 0, 1'b0);
		run_phase(fast, 55, 77, 0, 1'b0);
		run_phase(chatter, 55, 0, 77, 1'b0);
		run_phase(frozen, 55, 12, 12, 1'b0);
		run_phase(ext_hi, 55, 0, 0, 1'b0);
		run_phase(ext_lo, 55, 77, 0, 1'b0);
		// Spike on nearly every tick until the energy gauge bottoms out
		run_phase(regular, 300, 0, 77, 1'b1);
		run_phase(random_regs(), 55, 12, 12, 1'b0);
		run_phase(bursting, 55, 0, 0, 1'b0);

		repeat (2 * TICK_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
